// ===== rtl/cscv_pkg.sv =====
// ----------------------------------------------------------------------------
// cscv_pkg
// Shared constants and types for the cross stencil convolver.
// ----------------------------------------------------------------------------
package cscv_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int WT_BITS     = 16;
   localparam int MAX_WIDTH   = 128;
   localparam int MAX_HEIGHT  = 128;
   localparam int MAX_DEPTH   = 4096;

   localparam int DIM_BITS    = 8;    // width / height register
   localparam int DEPTH_BITS  = 13;   // depth register
   localparam int X_BITS      = $clog2(MAX_WIDTH);
   localparam int Y_BITS      = $clog2(MAX_HEIGHT);
   localparam int Z_BITS      = $clog2(MAX_DEPTH);
   localparam int WY_BITS     = X_BITS + Y_BITS;
   localparam int PLANE_BITS  = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
   localparam int IDX_BITS    = $clog2(MAX_WIDTH * MAX_HEIGHT * MAX_DEPTH) + 1;

   localparam int STORE_DEPTH = 2 * MAX_WIDTH * MAX_HEIGHT;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   localparam int CSR_AW      = 5;
   localparam int CSR_DW      = 32;

   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

   typedef enum logic [2:0] {
      REG_WIDTH   = 3'd0,
      REG_HEIGHT  = 3'd1,
      REG_DEPTH   = 3'd2,
      REG_MODE    = 3'd3,
      REG_BEFORE  = 3'd4,
      REG_CENTER  = 3'd5,
      REG_AFTER   = 3'd6
   } csr_reg_type;

   typedef enum logic {
      OPC_SAMPLE = 1'b0,
      OPC_DRAIN  = 1'b1
   } opcode_type;

   // control carried with an output word from issue to tap select
   typedef struct packed {
      logic                          last;
      logic                          slow;
      logic                          three_d;
      logic                          xlo;
      logic                          xhi;
      logic                          ylo;
      logic                          yhi;
      logic                          zlo;
      logic                          zhi;
      logic                          fwd_p1;
      logic                          fwd_pw;
      logic                          fwd_pp;
      logic signed [SAMPLE_BITS-1:0] nv;
   } tap_ctl_type;

endpackage

// ===== rtl/cross_stencil_convolver_top.sv =====
// ----------------------------------------------------------------------------
// cross_stencil_convolver_top
// Streaming three-tap cross stencil (x, y and optional z) with replicated
// borders, Q8.8 weights, truncation toward zero and 16-bit saturation.
// ----------------------------------------------------------------------------
// Samples arrive in raster order (x fastest, then y, then z), one word per
// clock while req_stall is low. The window lives in two identical copies of
// a 32768-entry sample store, both written with every sample and each read
// at two addresses per cycle. The result for position o comes out on the
// sample whose index is o + width (2-D) or o + width*height (3-D); drain
// words flush what is still pending, one result per drain word. Rate: one
// word per cycle in steady state. An output word needs a second read beat
// at the store when the center and left samples are not already held from
// the previous result (first result of a volume, or results after a sample
// overwrote them) or, in 3-D mode, when the plane-after tap is neither the
// incoming sample nor replicated: then that beat fetches left, center and
// plane-after and the input stalls during it. A register write stalls the
// input while plane size, volume size and the output index are recomputed.
// A result passes tap select, products, sum and saturate and the output
// queue in that order. An eight-word output queue with a credit count keeps
// results from being lost when the result side stalls.
module cross_stencil_convolver_top (
   input  logic                                   clock,
   input  logic                                   reset,
   // input words
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_opcode,
   input  logic signed [cscv_pkg::SAMPLE_BITS-1:0] req_sample,
   // result words
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [cscv_pkg::SAMPLE_BITS-1:0] rsp_filtered_sample,
   output logic                                   rsp_last_of_volume,
   // register port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [cscv_pkg::CSR_AW-1:0]            csr_paddr,
   input  logic [cscv_pkg::CSR_DW-1:0]            csr_pwdata,
   output logic [cscv_pkg::CSR_DW-1:0]            csr_prdata,
   output logic                                   csr_pready
);
   import cscv_pkg::*;

   // ---------------------------------------------------------------- config
   logic [DIM_BITS-1:0]          width_ff, height_ff;
   logic [DEPTH_BITS-1:0]        depth_ff;
   logic                         three_d_ff;
   logic signed [WT_BITS-1:0]    wb_ff, wc_ff, wa_ff;
   logic [PLANE_BITS-1:0]        plane_ff;   // width*height
   logic [IDX_BITS-1:0]          total_ff;   // plane*depth
   logic [1:0]                   settle_ff;

   // --------------------------------------------------------- stream state
   logic [IDX_BITS-1:0]          in_idx_ff,  in_idx_in;
   logic [X_BITS-1:0]            x_ff,       x_in;
   logic [Y_BITS-1:0]            y_ff,       y_in;
   logic [Z_BITS-1:0]            z_ff,       z_in;
   logic [WY_BITS-1:0]           wy_ff,      wy_in;   // width*y
   logic [IDX_BITS-1:0]          pz_ff,      pz_in;   // plane*z
   logic [IDX_BITS-1:0]          o_ff,       o_in;    // x + wy + pz
   logic                         done_ff,    done_in;

   // held center/left pair from the previous result
   logic [IDX_BITS-1:0]          pred_base_ff, pred_base_in;
   logic                         pred_ok_ff,   pred_ok_in;
   logic signed [SAMPLE_BITS-1:0] hold_a_ff, hold_b_ff;

   // --------------------------------------------------------------- store
   logic signed [SAMPLE_BITS-1:0] mem0 [STORE_DEPTH];
   logic signed [SAMPLE_BITS-1:0] mem1 [STORE_DEPTH];
   logic signed [SAMPLE_BITS-1:0] rd00_ff, rd01_ff, rd10_ff, rd11_ff;
   logic signed [SAMPLE_BITS-1:0] ah00_ff, ah01_ff, ah10_ff, ah11_ff;
   logic [STORE_AW-1:0]          ra00, ra01, ra10, ra11;
   logic                         we;
   logic [STORE_AW-1:0]          wa;
   logic signed [SAMPLE_BITS-1:0] wd;

   // second read beat and deferred write
   logic                         bpend_ff;
   logic [STORE_AW-1:0]          bad0_ff, bad1_ff, bad2_ff;
   logic                         pw_en_ff;
   logic [STORE_AW-1:0]          pw_addr_ff;
   logic signed [SAMPLE_BITS-1:0] pw_data_ff;

   // ------------------------------------------------------------ pipeline
   logic                         p1_valid_ff;
   tap_ctl_type                  p1_ctl_ff, ctl;
   logic                         s2_valid_ff, s2_last_ff;
   logic signed [SAMPLE_BITS-1:0] s2_c_ff;
   logic signed [SAMPLE_BITS+1:0] s2_lo_ff, s2_up_ff;
   logic                         s3_valid_ff, s3_last_ff;
   logic signed [2*SAMPLE_BITS-1:0] s3_pc_ff;
   logic signed [2*SAMPLE_BITS+1:0] s3_pl_ff, s3_pu_ff;

   // output queue
   logic [SAMPLE_BITS:0]         fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]           wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]             count_ff, reserved_ff;

   // ------------------------------------------------------- issue signals
   logic                         issue, is_drain, restart;
   logic [IDX_BITS-1:0]          e_idx, e_o, e_pz, len, o_p1;
   logic [X_BITS-1:0]            e_x;
   logic [Y_BITS-1:0]            e_y;
   logic [Z_BITS-1:0]            e_z;
   logic [WY_BITS-1:0]           e_wy;
   logic [IDX_BITS:0]            diff;
   logic                         sample_ok, samp_emit, drain_emit, emit, writing;
   logic                         xlo, xhi, ylo, yhi, zlo, zhi, last;
   logic                         fwd_p1, fwd_pw, fwd_pp, hold_ok, slow;
   logic [DIM_BITS-1:0]          nx, ny;
   logic [STORE_AW-1:0]          o15, w15, p15, cur15, nb15;

   // register writes
   logic                         csr_wr;
   csr_reg_type                  csr_idx;

   // ================================================================ CSR
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_reg_type'(csr_paddr[CSR_AW-1:2]);

   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                     input logic [DIM_BITS-1:0] hi);
      logic [DIM_BITS-1:0] r;
      r = v;
      if (v == '0) r = DIM_BITS'(1);
      else if (v > hi) r = hi;
      return r;
   endfunction

   always_comb begin
      csr_prdata = '0;
      unique case (csr_idx)
         REG_WIDTH:  csr_prdata = CSR_DW'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DW'(height_ff);
         REG_DEPTH:  csr_prdata = CSR_DW'(depth_ff);
         REG_MODE:   csr_prdata = CSR_DW'(three_d_ff);
         REG_BEFORE: csr_prdata = CSR_DW'($unsigned(wb_ff));
         REG_CENTER: csr_prdata = CSR_DW'($unsigned(wc_ff));
         REG_AFTER:  csr_prdata = CSR_DW'($unsigned(wa_ff));
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= DIM_BITS'(MAX_WIDTH);
         height_ff  <= DIM_BITS'(MAX_HEIGHT);
         depth_ff   <= DEPTH_BITS'(1);
         three_d_ff <= 1'b0;
         wb_ff      <= WT_BITS'(256);
         wc_ff      <= '0;
         wa_ff      <= WT_BITS'(256);
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_WIDTH:  width_ff  <= clamp_dim(csr_pwdata[DIM_BITS-1:0],
                                               DIM_BITS'(MAX_WIDTH));
            REG_HEIGHT: height_ff <= clamp_dim(csr_pwdata[DIM_BITS-1:0],
                                               DIM_BITS'(MAX_HEIGHT));
            REG_DEPTH: begin
               if (csr_pwdata[DEPTH_BITS-1:0] == '0)
                  depth_ff <= DEPTH_BITS'(1);
               else if (csr_pwdata[DEPTH_BITS-1:0] > DEPTH_BITS'(MAX_DEPTH))
                  depth_ff <= DEPTH_BITS'(MAX_DEPTH);
               else
                  depth_ff <= csr_pwdata[DEPTH_BITS-1:0];
            end
            REG_MODE:   three_d_ff <= csr_pwdata[0];
            REG_BEFORE: wb_ff <= $signed(csr_pwdata[WT_BITS-1:0]);
            REG_CENTER: wc_ff <= $signed(csr_pwdata[WT_BITS-1:0]);
            REG_AFTER:  wa_ff <= $signed(csr_pwdata[WT_BITS-1:0]);
            default: ;
         endcase
      end
   end

   // ============================================================ issue
   // Input is held off during the second read beat, while derived sizes
   // settle after a register write, and when every queue slot is promised.
   assign req_stall = bpend_ff | (settle_ff != 2'd0) |
                      (reserved_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign issue     = req_valid & ~req_stall;
   assign is_drain  = (opcode_type'(req_opcode) == OPC_DRAIN);

   always_comb begin
      // a sample after the end of a volume starts the next one
      restart = ~is_drain & done_ff;
      e_idx   = restart ? '0 : in_idx_ff;
      e_x     = restart ? '0 : x_ff;
      e_y     = restart ? '0 : y_ff;
      e_z     = restart ? '0 : z_ff;
      e_wy    = restart ? '0 : wy_ff;
      e_pz    = restart ? '0 : pz_ff;
      e_o     = restart ? '0 : o_ff;

      len  = three_d_ff ? IDX_BITS'(plane_ff) : IDX_BITS'(width_ff);
      diff = {1'b0, e_idx} - {1'b0, e_o};

      sample_ok  = ~is_drain & (e_idx < total_ff);
      samp_emit  = sample_ok & (e_o < total_ff) & ~diff[IDX_BITS] &
                   (diff[IDX_BITS-1:0] >= len);
      drain_emit = is_drain & ~done_ff & (e_o < in_idx_ff) & (e_o < total_ff);
      emit       = issue & (samp_emit | drain_emit);
      writing    = issue & sample_ok;

      nx  = {1'b0, e_x} + DIM_BITS'(1);
      ny  = {1'b0, e_y} + DIM_BITS'(1);
      xlo = (e_x == '0);
      xhi = (nx >= width_ff);
      ylo = (e_y == '0);
      yhi = (ny >= height_ff);
      zlo = (e_z == '0);
      zhi = (({1'b0, e_z} + DEPTH_BITS'(1)) >= depth_ff);

      // neighbours that are the sample arriving right now
      fwd_p1 = ~is_drain & (diff == (IDX_BITS+1)'(1));
      fwd_pw = ~is_drain & (diff == (IDX_BITS+1)'(width_ff));
      fwd_pp = ~is_drain & (diff == (IDX_BITS+1)'(plane_ff));

      hold_ok = pred_ok_ff & (pred_base_ff == e_o);
      slow    = ~hold_ok | (three_d_ff & ~zhi & ~fwd_pp);

      o_p1 = e_o + IDX_BITS'(1);
      last = (o_p1 >= total_ff);

      o15   = e_o[STORE_AW-1:0];
      w15   = STORE_AW'(width_ff);
      p15   = STORE_AW'(plane_ff);
      cur15 = e_idx[STORE_AW-1:0];

      ctl.last    = last;
      ctl.slow    = slow;
      ctl.three_d = three_d_ff;
      ctl.xlo     = xlo;
      ctl.xhi     = xhi;
      ctl.ylo     = ylo;
      ctl.yhi     = yhi;
      ctl.zlo     = zlo;
      ctl.zhi     = zhi;
      ctl.fwd_p1  = fwd_p1;
      ctl.fwd_pw  = fwd_pw;
      ctl.fwd_pp  = fwd_pp;
      ctl.nv      = req_sample;
   end

   // ------------------------------------------------ counter next values
   always_comb begin
      in_idx_in    = in_idx_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      wy_in        = wy_ff;
      pz_in        = pz_ff;
      done_in      = done_ff;
      pred_base_in = pred_base_ff;
      pred_ok_in   = pred_ok_ff;

      if (issue & ~is_drain) begin
         x_in    = e_x;
         y_in    = e_y;
         z_in    = e_z;
         wy_in   = e_wy;
         pz_in   = e_pz;
         done_in = 1'b0;
         in_idx_in = sample_ok ? e_idx + IDX_BITS'(1) : e_idx;
      end

      if (emit) begin
         pred_base_in = o_p1;
         pred_ok_in   = 1'b1;
         if (last) begin
            x_in    = '0;
            y_in    = '0;
            z_in    = '0;
            wy_in   = '0;
            pz_in   = '0;
            done_in = 1'b1;
         end else if (nx >= width_ff) begin
            x_in = '0;
            if (ny >= height_ff) begin
               y_in  = '0;
               z_in  = e_z + Z_BITS'(1);
               wy_in = '0;
               pz_in = e_pz + IDX_BITS'(plane_ff);
            end else begin
               y_in  = ny[Y_BITS-1:0];
               wy_in = e_wy + WY_BITS'(width_ff);
            end
         end else begin
            x_in = nx[X_BITS-1:0];
         end
      end

      // a sample landing on the held pair spoils it
      nb15 = pred_base_in[STORE_AW-1:0];
      if (writing && ((cur15 == nb15) || (cur15 == nb15 - STORE_AW'(1))))
         pred_ok_in = 1'b0;

      o_in = IDX_BITS'(x_in) + IDX_BITS'(wy_in) + pz_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_idx_ff    <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         z_ff         <= '0;
         wy_ff        <= '0;
         pz_ff        <= '0;
         o_ff         <= '0;
         done_ff      <= 1'b0;
         pred_base_ff <= '0;
         pred_ok_ff   <= 1'b0;
         settle_ff    <= 2'd0;
         plane_ff     <= PLANE_BITS'(MAX_WIDTH * MAX_HEIGHT);
         total_ff     <= IDX_BITS'(MAX_WIDTH * MAX_HEIGHT);
      end else if (csr_wr) begin
         settle_ff <= 2'd3;
      end else if (settle_ff != 2'd0) begin
         // recompute derived sizes and the output index, one multiply deep
         settle_ff <= settle_ff - 2'd1;
         unique case (settle_ff)
            2'd3: begin
               plane_ff <= {{(PLANE_BITS-DIM_BITS){1'b0}}, width_ff} *
                           {{(PLANE_BITS-DIM_BITS){1'b0}}, height_ff};
               wy_ff    <= WY_BITS'(width_ff) * WY_BITS'(y_ff);
            end
            2'd2: begin
               pz_ff    <= IDX_BITS'(plane_ff) * IDX_BITS'(z_ff);
               total_ff <= IDX_BITS'(plane_ff) * IDX_BITS'(depth_ff);
            end
            2'd1:    o_ff <= IDX_BITS'(x_ff) + IDX_BITS'(wy_ff) + pz_ff;
            default: ;
         endcase
      end else begin
         in_idx_ff    <= in_idx_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         z_ff         <= z_in;
         wy_ff        <= wy_in;
         pz_ff        <= pz_in;
         o_ff         <= o_in;
         done_ff      <= done_in;
         pred_base_ff <= pred_base_in;
         pred_ok_ff   <= pred_ok_in;
      end
   end

   // ============================================================ store
   // beat A: right, row-before, row-after, plane-before
   // beat B: left, center, plane-after
   always_comb begin
      if (bpend_ff) begin
         ra00 = bad0_ff;
         ra01 = bad1_ff;
         ra10 = bad2_ff;
         ra11 = bad2_ff;
      end else begin
         ra00 = o15 + STORE_AW'(1);
         ra01 = o15 - w15;
         ra10 = o15 + w15;
         ra11 = o15 - p15;
      end
      // a slow word writes its sample in beat B, after all its reads
      we = 1'b0;
      wa = cur15;
      wd = req_sample;
      if (bpend_ff) begin
         we = pw_en_ff;
         wa = pw_addr_ff;
         wd = pw_data_ff;
      end else if (writing && !(emit && slow)) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem0[wa] <= wd;
      rd00_ff <= mem0[ra00];
      rd01_ff <= mem0[ra01];
   end

   always_ff @(posedge clock) begin
      if (we) mem1[wa] <= wd;
      rd10_ff <= mem1[ra10];
      rd11_ff <= mem1[ra11];
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         bad0_ff    <= o15 - STORE_AW'(1);
         bad1_ff    <= o15;
         bad2_ff    <= o15 + p15;
         pw_addr_ff <= cur15;
         pw_data_ff <= req_sample;
      end
      if (bpend_ff) begin
         ah00_ff <= rd00_ff;
         ah01_ff <= rd01_ff;
         ah10_ff <= rd10_ff;
         ah11_ff <= rd11_ff;
      end
      if (emit) p1_ctl_ff <= ctl;
   end

   // ====================================================== tap select
   logic                          fire;
   logic signed [SAMPLE_BITS-1:0] a00, a01, a10, a11;
   logic signed [SAMPLE_BITS-1:0] vc, vm1, vp1, vmw, vpw, vmp, vpp;
   logic signed [SAMPLE_BITS-1:0] l0, l1, l2, u0, u1, u2;
   logic signed [SAMPLE_BITS+1:0] lo_sum, up_sum;

   assign fire = p1_valid_ff & ~bpend_ff;

   always_comb begin
      a00 = p1_ctl_ff.slow ? ah00_ff : rd00_ff;
      a01 = p1_ctl_ff.slow ? ah01_ff : rd01_ff;
      a10 = p1_ctl_ff.slow ? ah10_ff : rd10_ff;
      a11 = p1_ctl_ff.slow ? ah11_ff : rd11_ff;
      vm1 = p1_ctl_ff.slow ? rd00_ff : hold_a_ff;
      vc  = p1_ctl_ff.slow ? rd01_ff : hold_b_ff;
      vp1 = p1_ctl_ff.fwd_p1 ? p1_ctl_ff.nv : a00;
      vmw = a01;
      vpw = p1_ctl_ff.fwd_pw ? p1_ctl_ff.nv : a10;
      vmp = a11;
      vpp = p1_ctl_ff.fwd_pp ? p1_ctl_ff.nv : rd10_ff;
      // borders replicate the center
      l0 = p1_ctl_ff.xlo ? vc : vm1;
      l1 = p1_ctl_ff.ylo ? vc : vmw;
      l2 = p1_ctl_ff.zlo ? vc : vmp;
      u0 = p1_ctl_ff.xhi ? vc : vp1;
      u1 = p1_ctl_ff.yhi ? vc : vpw;
      u2 = p1_ctl_ff.zhi ? vc : vpp;
      lo_sum = (SAMPLE_BITS+2)'(l0) + (SAMPLE_BITS+2)'(l1) +
               (p1_ctl_ff.three_d ? (SAMPLE_BITS+2)'(l2) : '0);
      up_sum = (SAMPLE_BITS+2)'(u0) + (SAMPLE_BITS+2)'(u1) +
               (p1_ctl_ff.three_d ? (SAMPLE_BITS+2)'(u2) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         bpend_ff    <= 1'b0;
         pw_en_ff    <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= emit | (p1_valid_ff & ~fire);
         bpend_ff    <= emit & slow;
         pw_en_ff    <= writing;
         s2_valid_ff <= fire;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         // next result picks left/center from here
         hold_a_ff  <= vc;
         hold_b_ff  <= vp1;
         s2_c_ff    <= vc;
         s2_lo_ff   <= lo_sum;
         s2_up_ff   <= up_sum;
         s2_last_ff <= p1_ctl_ff.last;
      end
      s3_pc_ff   <= s2_c_ff * wc_ff;
      s3_pl_ff   <= s2_lo_ff * wb_ff;
      s3_pu_ff   <= s2_up_ff * wa_ff;
      s3_last_ff <= s2_last_ff;
   end

   // ===================================================== sum and clip
   localparam int ACC_BITS = 2 * SAMPLE_BITS + 4;
   localparam logic signed [ACC_BITS-1:0] SAT_MAX = ACC_BITS'((1 << (SAMPLE_BITS-1)) - 1);
   localparam logic signed [ACC_BITS-1:0] SAT_MIN = -SAT_MAX - ACC_BITS'(1);

   logic signed [ACC_BITS-1:0]    acc, acc_adj, quo;
   logic signed [SAMPLE_BITS-1:0] sat;

   always_comb begin
      acc     = ACC_BITS'(s3_pc_ff) + ACC_BITS'(s3_pl_ff) + ACC_BITS'(s3_pu_ff);
      // divide by 256 toward zero
      acc_adj = acc[ACC_BITS-1] ? acc + ACC_BITS'(255) : acc;
      quo     = acc_adj >>> 8;
      if (quo > SAT_MAX)      sat = SAT_MAX[SAMPLE_BITS-1:0];
      else if (quo < SAT_MIN) sat = SAT_MIN[SAMPLE_BITS-1:0];
      else                    sat = quo[SAMPLE_BITS-1:0];
   end

   // ===================================================== output queue
   logic pop;
   assign rsp_valid           = (count_ff != '0);
   assign pop                 = rsp_valid & ~rsp_stall;
   assign rsp_filtered_sample = $signed(fifo_ff[rd_ptr_ff][SAMPLE_BITS-1:0]);
   assign rsp_last_of_volume  = fifo_ff[rd_ptr_ff][SAMPLE_BITS];

   always_ff @(posedge clock) begin
      if (s3_valid_ff) fifo_ff[wr_ptr_ff] <= {s3_last_ff, sat};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         reserved_ff <= '0;
      end else begin
         if (s3_valid_ff) wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         if (pop)         rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         count_ff    <= count_ff + (FIFO_AW+1)'(s3_valid_ff) - (FIFO_AW+1)'(pop);
         // a slot is promised at issue and freed when the word leaves
         reserved_ff <= reserved_ff + (FIFO_AW+1)'(emit) - (FIFO_AW+1)'(pop);
      end
   end

endmodule

// ===== tb/sv/tb_cross_stencil_convolver_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cross_stencil_convolver_top
// Self-checking bench for the cross stencil convolver. A directed table
// covers saturation at both rails, drains with and without pending work,
// excess samples and restart of a volume; random phases then sweep the
// dimensions, the 2-D/3-D mode and the weights with random gaps on both
// channels. Each result word is checked against the table or in-bench predictor.
// ----------------------------------------------------------------------------
module tb_cross_stencil_convolver_top;
   import cscv_pkg::*;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int SETTLE_CYCLES  = 12;   // pipeline latency plus margin

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] value;
      logic                          last;
   } result_word_t;

   typedef struct {
      opcode_type                    op;
      logic signed [SAMPLE_BITS-1:0] smp;
      bit                            typed;   // expectation typed in below
      bit                            t_has;
      logic signed [SAMPLE_BITS-1:0] t_value;
      logic                          t_last;
   } table_row_t;

   // DUT signals, all known from time zero
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_opcode = OPC_SAMPLE;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_filtered_sample;
   logic                          rsp_last_of_volume;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]             csr_paddr = '0;
   logic [CSR_DW-1:0]             csr_pwdata = '0;
   logic [CSR_DW-1:0]             csr_prdata;
   logic                          csr_pready;

   cross_stencil_convolver_top u_top (.*);

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: its own copy of registers, counters and the window
   // ---------------------------------------------------------------------
   int unsigned cfg_width, cfg_height, cfg_depth;
   bit          cfg_3d;
   logic signed [15:0] wt_before, wt_center, wt_after;

   logic signed [SAMPLE_BITS-1:0] window_copy [STORE_DEPTH];
   bit                            window_ok   [STORE_DEPTH];
   int unsigned in_count;
   int unsigned out_x, out_y, out_z;
   bit          vol_done;
   bit          touched_unwritten;

   result_word_t pending_results[$];
   int  errors = 0;
   bit  quiet = 0;           // no sender gaps while set
   int  words_sent = 0;

   function automatic void clear_predictor();
      cfg_width = 128; cfg_height = 128; cfg_depth = 1; cfg_3d = 0;
      wt_before = 16'sd256; wt_center = 16'sd0; wt_after = 16'sd256;
      in_count = 0; out_x = 0; out_y = 0; out_z = 0; vol_done = 0;
      foreach (window_ok[i]) window_ok[i] = 0;
   endfunction

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned out_pos();
      return out_x + cfg_width * out_y + cfg_width * cfg_height * out_z;
   endfunction

   // tap read; the incoming sample wins over the store
   function automatic longint tap(int unsigned j, bit have, int unsigned cur,
                                  logic signed [SAMPLE_BITS-1:0] nv);
      if (have && j == cur) return longint'(nv);
      if (!window_ok[j % STORE_DEPTH]) touched_unwritten = 1;
      return longint'(window_copy[j % STORE_DEPTH]);
   endfunction

   // result at the current output position, no state change
   function automatic result_word_t stencil_value(bit have, int unsigned cur,
                                                  logic signed [SAMPLE_BITS-1:0] nv);
      int unsigned w, p, n, o;
      longint c, lo, up, acc, q;
      result_word_t r;
      w = cfg_width; p = w * cfg_height; n = p * cfg_depth; o = out_pos();
      c  = tap(o, have, cur, nv);
      lo = (out_x == 0) ? c : tap(o - 1, have, cur, nv);
      up = (out_x + 1 >= w) ? c : tap(o + 1, have, cur, nv);
      lo += (out_y == 0) ? c : tap(o - w, have, cur, nv);
      up += (out_y + 1 >= cfg_height) ? c : tap(o + w, have, cur, nv);
      if (cfg_3d) begin
         lo += (out_z == 0) ? c : tap(o - p, have, cur, nv);
         up += (out_z + 1 >= cfg_depth) ? c : tap(o + p, have, cur, nv);
      end
      acc = c * longint'(wt_center) + lo * longint'(wt_before)
          + up * longint'(wt_after);
      q = acc / 256;   // truncates toward zero
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      r.value = q[SAMPLE_BITS-1:0];
      r.last  = (o + 1 >= n);
      return r;
   endfunction

   function automatic void advance_pos();
      int unsigned n;
      n = cfg_width * cfg_height * cfg_depth;
      if (out_pos() + 1 >= n) begin
         out_x = 0; out_y = 0; out_z = 0; vol_done = 1;
         return;
      end
      out_x++;
      if (out_x >= cfg_width) begin
         out_x = 0;
         out_y++;
         if (out_y >= cfg_height) begin
            out_y = 0;
            out_z++;
         end
      end
   endfunction

   // would a drain now read a never-written store entry?
   function automatic bit drain_safe();
      int unsigned o, n;
      result_word_t r;
      if (vol_done) return 1;
      o = out_pos(); n = cfg_width * cfg_height * cfg_depth;
      if (!(o < in_count && o < n)) return 1;
      touched_unwritten = 0;
      r = stencil_value(0, 0, '0);
      return !touched_unwritten;
   endfunction

   function automatic bit stencil_predict(opcode_type op,
                                          logic signed [SAMPLE_BITS-1:0] smp,
                                          output result_word_t r);
      int unsigned w, p, n, l, o, cur;
      bit has;
      has = 0;
      w = cfg_width; p = w * cfg_height; n = p * cfg_depth;
      l = cfg_3d ? p : w;
      if (op == OPC_DRAIN) begin
         if (!vol_done) begin
            o = out_pos();
            if (o < in_count && o < n) begin
               r = stencil_value(0, 0, '0);
               advance_pos();
               has = 1;
            end
         end
         return has;
      end
      if (vol_done) begin
         vol_done = 0; in_count = 0; out_x = 0; out_y = 0; out_z = 0;
      end
      if (in_count >= n) return 0;
      cur = in_count;
      o = out_pos();
      in_count = cur + 1;
      if (o < n && o + l <= cur) begin
         r = stencil_value(1, cur, smp);
         advance_pos();
         has = 1;
      end
      window_copy[cur % STORE_DEPTH] = smp;
      window_ok[cur % STORE_DEPTH] = 1;
      return has;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // one word on the input channel; predictor runs at the accepting edge
   task automatic send_word(opcode_type op, logic signed [SAMPLE_BITS-1:0] smp,
                            bit typed = 0, bit t_has = 0,
                            logic signed [SAMPLE_BITS-1:0] t_value = '0,
                            logic t_last = 0);
      int n;
      result_word_t r;
      bit has;
      n = quiet ? 0 : gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_sample <= smp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      has = stencil_predict(op, smp, r);
      if (typed) begin
         has = t_has;
         r.value = t_value;
         r.last  = t_last;
      end
      if (has) pending_results.push_back(r);
      words_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(csr_reg_type idx, logic [CSR_DW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(4 * int'(idx));
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);   // write lands here, pready is tied high
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_WIDTH:  cfg_width  = clamp_dim(data & 32'hFF, MAX_WIDTH);
         REG_HEIGHT: cfg_height = clamp_dim(data & 32'hFF, MAX_HEIGHT);
         REG_DEPTH:  cfg_depth  = clamp_dim(data & 32'h1FFF, MAX_DEPTH);
         REG_MODE:   cfg_3d     = data[0];
         REG_BEFORE: wt_before  = data[15:0];
         REG_CENTER: wt_center  = data[15:0];
         REG_AFTER:  wt_after   = data[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_all(int unsigned w, int unsigned h, int unsigned d, bit m,
                            logic [15:0] wb, logic [15:0] wc, logic [15:0] wa);
      csr_write(REG_WIDTH, w);
      csr_write(REG_HEIGHT, h);
      csr_write(REG_DEPTH, d);
      csr_write(REG_MODE, m);
      csr_write(REG_BEFORE, wb);
      csr_write(REG_CENTER, wc);
      csr_write(REG_AFTER, wa);
   endtask

   function automatic logic [15:0] pick_weight();
      logic [15:0] edge_w [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0100};
      if ($urandom_range(0, 4) == 0) return edge_w[$urandom_range(0, 3)];
      return $urandom_range(0, 65535);
   endfunction

   // one volume: samples with occasional early drains, optional excess
   // samples, then drains until the last word is out plus one spare
   task automatic run_volume(bit pause_mid);
      int unsigned n;
      n = cfg_width * cfg_height * cfg_depth;
      for (int unsigned i = 0; i < n; i++) begin
         if (pause_mid && i == n / 2) wait_idle();   // hold off until drained
         if ($urandom_range(0, 99) < 6 && drain_safe())
            send_word(OPC_DRAIN, $urandom_range(0, 65535));
         send_word(OPC_SAMPLE, $urandom_range(0, 65535));
      end
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3)) send_word(OPC_SAMPLE, $urandom_range(0, 65535));
      while (!vol_done) send_word(OPC_DRAIN, $urandom_range(0, 65535));
      send_word(OPC_DRAIN, $urandom_range(0, 65535));   // nothing pending
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stall runs, compare against the oldest expectation
   // ---------------------------------------------------------------------
   int stall_hold = 0;
   always @(posedge clock) begin
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else if (rsp_stall) begin
         rsp_stall  <= 1'b0;
         stall_hold <= $urandom_range(0, 30);
      end else begin
         rsp_stall  <= 1'b1;
         stall_hold <= gap_len();
      end
   end

   always @(posedge clock) begin
      result_word_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result word value %0d last %0b", $realtime,
                     rsp_filtered_sample, rsp_last_of_volume);
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_filtered_sample !== e.value) begin
               $display("%0t: filtered_sample expected %0d got %0d", $realtime,
                        e.value, rsp_filtered_sample);
               errors++;
            end
            if (rsp_last_of_volume !== e.last) begin
               $display("%0t: last_of_volume expected %0b got %0b", $realtime,
                        e.last, rsp_last_of_volume);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles with no word moving on either channel
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding", $realtime,
                  pending_results.size());
         $display("** cross_stencil_convolver_top: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      table_row_t rows[$];
      int phase;
      int unsigned w, h, d;

      clear_predictor();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 2x1x1 image, all weights 1.0: every output is 5*center-ish, so
      // rail inputs saturate to the same rail
      write_all(2, 1, 1, 0, 16'h0100, 16'h0100, 16'h0100);
      rows.push_back('{OPC_SAMPLE, 16'sh7FFF, 1, 0, 16'sh0, 0});
      rows.push_back('{OPC_SAMPLE, 16'sh7FFF, 1, 0, 16'sh0, 0});
      rows.push_back('{OPC_SAMPLE, 16'sh1234, 1, 0, 16'sh0, 0});    // excess
      rows.push_back('{OPC_DRAIN,  16'sh0,    1, 1, 16'sh7FFF, 0});
      rows.push_back('{OPC_DRAIN,  16'sh0,    1, 1, 16'sh7FFF, 1});
      rows.push_back('{OPC_DRAIN,  16'shFFFF, 1, 0, 16'sh0, 0});    // nothing pending
      rows.push_back('{OPC_SAMPLE, 16'sh8000, 1, 0, 16'sh0, 0});    // new volume
      rows.push_back('{OPC_SAMPLE, 16'sh8000, 1, 0, 16'sh0, 0});
      rows.push_back('{OPC_DRAIN,  16'sh0,    1, 1, 16'sh8000, 0});
      rows.push_back('{OPC_DRAIN,  16'sh0,    1, 1, 16'sh8000, 1});
      rows.push_back('{OPC_SAMPLE, 16'sh0,    1, 0, 16'sh0, 0});
      rows.push_back('{OPC_SAMPLE, 16'sh0,    1, 0, 16'sh0, 0});
      rows.push_back('{OPC_DRAIN,  16'sh0,    1, 1, 16'sh0, 0});
      rows.push_back('{OPC_DRAIN,  16'sh0,    1, 1, 16'sh0, 1});
      rows.push_back('{OPC_SAMPLE, 16'sh0064, 0, 0, 16'sh0, 0});
      rows.push_back('{OPC_SAMPLE, 16'shFFF9, 0, 0, 16'sh0, 0});
      rows.push_back('{OPC_DRAIN,  16'sh0,    0, 0, 16'sh0, 0});
      rows.push_back('{OPC_DRAIN,  16'sh0,    0, 0, 16'sh0, 0});
      foreach (rows[i])
         send_word(rows[i].op, rows[i].smp, rows[i].typed, rows[i].t_has,
                   rows[i].t_value, rows[i].t_last);
      wait_idle();

      // random phases, mostly small volumes; clamp extremes now and then
      phase = 0;
      while (words_sent < 750) begin
         w = $urandom_range(1, 8);
         h = $urandom_range(1, 8);
         d = $urandom_range(1, 4);
         case ($urandom_range(0, 9))
            0: begin w = 255; h = $urandom_range(0, 2); end   // width clamps to max
            1: begin w = 0; h = 255; end                      // 1 x max column
            2: d = 0;                                         // depth clamps to 1
            default: ;
         endcase
         write_all(w, h, d, $urandom_range(0, 1), pick_weight(), pick_weight(),
                   pick_weight());
         quiet = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 3)) run_volume(phase == 2);
         quiet = 0;
         wait_idle();
         phase++;
      end

      // deepest volume, one sample per row and plane, z taps on
      write_all(1, 1, 8191, 1, pick_weight(), pick_weight(), pick_weight());
      quiet = 1;
      run_volume(0);
      quiet = 0;

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("** cross_stencil_convolver_top: PASSED **");
      else
         $display("** cross_stencil_convolver_top: FAILED **");
      $finish;
   end

endmodule

// ===== cross_stencil_convolver_top.f =====
rtl/cscv_pkg.sv
rtl/cross_stencil_convolver_top.sv
tb/sv/tb_cross_stencil_convolver_top.sv
